@@ src/avgp_pkg.sv @@
`default_nettype none

package avgp_pkg;

  // default upper limits of the image side and the pixel channel count
  localparam int unsigned MAX_SIDE_DEF     = 64;
  localparam int unsigned MAX_CHANNELS_DEF = 64;

  // fixed field widths
  localparam int unsigned SAMPLE_W    = 8;
  localparam int unsigned HALF_SIDE_W = 6;
  localparam int unsigned GROUPS_W    = 5;

  // configuration port
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned REG_SEL_BIT = 2;

  typedef enum logic {
    REG_HALF_SIDE      = 1'b0,
    REG_CHANNEL_GROUPS = 1'b1
  } reg_idx_e;

  // floor((a+b)/2) on signed samples
  function automatic logic signed [SAMPLE_W-1:0] half_add(
    input logic signed [SAMPLE_W-1:0] a,
    input logic signed [SAMPLE_W-1:0] b
  );
    logic signed [SAMPLE_W:0] sum;
    sum = {a[SAMPLE_W-1], a} + {b[SAMPLE_W-1], b};
    return sum[SAMPLE_W:1];
  endfunction

endpackage

`default_nettype wire

@@ src/avgp_in_if.sv @@
`default_nettype none

interface avgp_in_if import avgp_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

@@ src/avgp_out_if.sv @@
`default_nettype none

interface avgp_out_if import avgp_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] pooled;
  logic                       frame_last;

  modport source (output valid, output pooled, output frame_last, input ready);
  modport sink   (input valid, input pooled, input frame_last, output ready);
endinterface

`default_nettype wire

@@ src/avgp_ram.sv @@
`default_nettype none

module avgp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ src/avgp_front.sv @@
`default_nettype none

module avgp_front import avgp_pkg::*; #(
  parameter int unsigned MAX_SIDE     = MAX_SIDE_DEF,
  parameter int unsigned MAX_CHANNELS = MAX_CHANNELS_DEF,
  localparam int unsigned ChW   = $clog2(MAX_CHANNELS),
  localparam int unsigned ColW  = $clog2(MAX_SIDE),
  localparam int unsigned AddrW = $clog2((MAX_SIDE / 2) * MAX_CHANNELS),
  localparam int unsigned ItemW = SAMPLE_W + ChW + AddrW + 3
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [HALF_SIDE_W-1:0] half_side_i,
  input  wire logic [GROUPS_W-1:0]    channel_groups_i,
  avgp_in_if.sink                     in_i,
  input  wire logic                   q_ready_i,
  output logic                        push_o,
  output logic [ItemW-1:0]            item_o
);

  localparam int unsigned SideW  = $clog2(MAX_SIDE + 1);
  localparam int unsigned ChansW = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned ProdW  = ColW + ChansW;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [ChW-1:0]             ch;
    logic [AddrW-1:0]           sidx;
    logic                       odd_col;
    logic                       odd_row;
    logic                       last;
  } item_t;

  logic [ChW-1:0]    ch_q, ch_d;
  logic [ColW-1:0]   col_q, col_d, row_q, row_d;
  logic [SideW-1:0]  side;
  logic [ChansW-1:0] chans;
  logic [ColW-1:0]   pair_col;
  logic [ProdW-1:0]  prod;
  item_t             item;

  // clamp registers to the supported range, zero acts as one
  always_comb begin
    if (half_side_i == '0) begin
      side = SideW'(2);
    end else if (32'(half_side_i) > MAX_SIDE / 2) begin
      side = SideW'(MAX_SIDE);
    end else begin
      side = SideW'(32'(half_side_i) * 2);
    end
    if (channel_groups_i == '0) begin
      chans = ChansW'(4);
    end else if (32'(channel_groups_i) > MAX_CHANNELS / 4) begin
      chans = ChansW'(MAX_CHANNELS);
    end else begin
      chans = ChansW'(32'(channel_groups_i) * 4);
    end
  end

  assign push_o     = in_i.valid && q_ready_i;
  assign in_i.ready = q_ready_i;

  assign pair_col = col_q >> 1;
  assign prod     = ProdW'(pair_col) * ProdW'(chans);

  always_comb begin
    item.sample  = in_i.sample;
    item.ch      = ch_q;
    item.sidx    = AddrW'(prod + ProdW'(ch_q));
    item.odd_col = col_q[0];
    item.odd_row = row_q[0];
    item.last    = (32'(row_q) == 32'(side) - 1) && (32'(col_q) == 32'(side) - 1) &&
                   (32'(ch_q) == 32'(chans) - 1);
  end

  assign item_o = item;

  // counters wrap when at or past their limit
  always_comb begin
    ch_d  = ch_q;
    col_d = col_q;
    row_d = row_q;
    if (push_o) begin
      if (32'(ch_q) + 1 >= 32'(chans)) begin
        ch_d = '0;
        if (32'(col_q) + 1 >= 32'(side)) begin
          col_d = '0;
          if (32'(row_q) + 1 >= 32'(side)) begin
            row_d = '0;
          end else begin
            row_d = row_q + 1'b1;
          end
        end else begin
          col_d = col_q + 1'b1;
        end
      end else begin
        ch_d = ch_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q  <= '0;
      col_q <= '0;
      row_q <= '0;
    end else begin
      ch_q  <= ch_d;
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

`default_nettype wire

@@ src/avgp_queue.sv @@
`default_nettype none

module avgp_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  ready_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic      [WIDTH-1:0] data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign ready_o = count_q != CntW'(DEPTH);
  assign valid_o = count_q != '0;
  assign data_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (32'(wr_ptr_q) == DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (32'(rd_ptr_q) == DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // fill level rises on a push without a pop
  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> count_q == $past(count_q) + 1'b1)
    else $error("queue fill level did not rise on push");

endmodule

`default_nettype wire

@@ src/avgp_back.sv @@
`default_nettype none

module avgp_back import avgp_pkg::*; #(
  parameter int unsigned MAX_SIDE     = MAX_SIDE_DEF,
  parameter int unsigned MAX_CHANNELS = MAX_CHANNELS_DEF,
  localparam int unsigned ChW   = $clog2(MAX_CHANNELS),
  localparam int unsigned AddrW = $clog2((MAX_SIDE / 2) * MAX_CHANNELS),
  localparam int unsigned ItemW = SAMPLE_W + ChW + AddrW + 3
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             q_valid_i,
  input  wire logic [ItemW-1:0] q_item_i,
  output logic                  q_pop_o,
  avgp_out_if.source            out_o
);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [ChW-1:0]             ch;
    logic [AddrW-1:0]           sidx;
    logic                       odd_col;
    logic                       odd_row;
    logic                       last;
  } item_t;

  item_t                      head, s1_q;
  logic                       s1_valid_q, s1_valid_d;
  logic                       needs_out, adv;
  logic signed [SAMPLE_W-1:0] hold_rd, first_rd, pair, avg;
  logic                       out_valid_q, out_valid_d;
  logic signed [SAMPLE_W-1:0] pooled_q;
  logic                       last_q;
  logic                       store_we;

  assign head      = q_item_i;
  assign needs_out = s1_q.odd_col && s1_q.odd_row;
  // work stage moves unless it holds a result and the output beat is stuck
  assign adv       = !s1_valid_q || !needs_out || !out_valid_q || out_o.ready;
  assign q_pop_o   = q_valid_i && adv;

  // even-column sample per channel
  avgp_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_CHANNELS)
  ) u_hold (
    .clk_i   (clk_i),
    .we_i    (q_pop_o && !head.odd_col),
    .waddr_i (head.ch),
    .wdata_i (head.sample),
    .re_i    (q_pop_o && head.odd_col),
    .raddr_i (head.ch),
    .rdata_o (hold_rd)
  );

  assign pair     = half_add(hold_rd, s1_q.sample);
  assign avg      = half_add(pair, first_rd);
  assign store_we = s1_valid_q && adv && s1_q.odd_col && !s1_q.odd_row;

  // first-row pair averages
  avgp_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH ((MAX_SIDE / 2) * MAX_CHANNELS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (s1_q.sidx),
    .wdata_i (pair),
    .re_i    (q_pop_o && head.odd_col && head.odd_row),
    .raddr_i (head.sidx),
    .rdata_o (first_rd)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (adv) begin
      s1_valid_d = q_pop_o;
    end
    out_valid_d = out_valid_q;
    if (s1_valid_q && adv && needs_out) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      s1_q <= head;
    end
    if (s1_valid_q && adv && needs_out) begin
      pooled_q <= avg;
      last_q   <= s1_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.pooled     = pooled_q;
  assign out_o.frame_last = last_q;

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !adv) |=> (s1_valid_q && $stable(s1_q)))
    else $error("stalled work item changed");

  a_no_pop_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !adv) |-> !q_pop_o)
    else $error("queue popped while work stage stalled");

endmodule

`default_nettype wire

@@ src/avg_pool_2x2_int8_hwc_top.sv @@
// a result is registered once its window's last sample has left the queue and work stage
// throughput: one sample per cycle while the output side takes beats
// the rate is set by at most one read of each line store per sample and one output register
// reset: counters clear to the first sample of a frame, half_side and channel_groups to 1
// line stores are not cleared, within a frame at one size every entry is written before it is read
`default_nettype none

module avg_pool_2x2_int8_hwc_top import avgp_pkg::*; #(
  parameter int unsigned MAX_SIDE     = MAX_SIDE_DEF,
  parameter int unsigned MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  avgp_in_if.sink                    in_i,
  avgp_out_if.source                 out_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int unsigned ChW   = $clog2(MAX_CHANNELS);
  localparam int unsigned AddrW = $clog2((MAX_SIDE / 2) * MAX_CHANNELS);
  // sample, channel, store index and three flags
  localparam int unsigned ItemW = SAMPLE_W + ChW + AddrW + 3;
  localparam int unsigned QueueDepth = 2;

  logic [HALF_SIDE_W-1:0] half_side_q, half_side_d;
  logic [GROUPS_W-1:0]    groups_q, groups_d;
  reg_idx_e               reg_idx;
  logic                   cfg_wr;

  logic             push, q_ready, q_valid, q_pop;
  logic [ItemW-1:0] front_item, queue_item;

  // ---------------------------------------------------------------------------
  // configuration registers, no wait states
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[REG_SEL_BIT]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    half_side_d = half_side_q;
    groups_d    = groups_q;
    prdata      = '0;
    case (reg_idx)
      REG_HALF_SIDE: begin
        prdata = APB_DATA_W'(half_side_q);
        if (cfg_wr) begin
          half_side_d = pwdata[HALF_SIDE_W-1:0];
        end
      end
      REG_CHANNEL_GROUPS: begin
        prdata = APB_DATA_W'(groups_q);
        if (cfg_wr) begin
          groups_d = pwdata[GROUPS_W-1:0];
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_side_q <= HALF_SIDE_W'(1);
      groups_q    <= GROUPS_W'(1);
    end else begin
      half_side_q <= half_side_d;
      groups_q    <= groups_d;
    end
  end

  // ---------------------------------------------------------------------------
  // front: takes samples, tracks channel/column/row and tags each beat
  // ---------------------------------------------------------------------------
  avgp_front #(
    .MAX_SIDE     (MAX_SIDE),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .half_side_i      (half_side_q),
    .channel_groups_i (groups_q),
    .in_i             (in_i),
    .q_ready_i        (q_ready),
    .push_o           (push),
    .item_o           (front_item)
  );

  // short queue so front and back stall independently
  avgp_queue #(
    .WIDTH (ItemW),
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_item),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (queue_item)
  );

  // ---------------------------------------------------------------------------
  // back: line store access, cascaded halving and output register
  // ---------------------------------------------------------------------------
  avgp_back #(
    .MAX_SIDE     (MAX_SIDE),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_item_i  (queue_item),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

endmodule

`default_nettype wire

@@ sim/tb_avg_pool_2x2_int8_hwc_top.sv @@
`timescale 1ns / 100ps

module tb_avg_pool_2x2_int8_hwc_top;
  import avgp_pkg::*;

  // run guard, far above the slowest legal run with every gap and stall at its longest
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  // slack after the last owed beat before touching registers
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned RANDOM_BEATS = 300;

  localparam int unsigned STORE_DEPTH = (MAX_SIDE_DEF / 2) * MAX_CHANNELS_DEF;

  // flavors of sample content
  typedef enum int unsigned {
    MIX_UNIFORM,
    MIX_EXTREME,
    MIX_SMALL
  } sample_mix_e;

  // one pooled output beat as the scoreboard holds it
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] pooled;
    logic                       frame_last;
  } pooled_beat_t;

  logic clk;
  logic rst_n;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  avgp_in_if  in_if ();
  avgp_out_if out_if ();

  avg_pool_2x2_int8_hwc_top dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // free-running clock, 8 ns period
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // shadow of the two registers as written (raw, before clamping)
  logic [HALF_SIDE_W-1:0] cfg_half   = HALF_SIDE_W'(1);
  logic [GROUPS_W-1:0]    cfg_groups = GROUPS_W'(1);

  // shadow of the line stores and the raster counters
  logic signed [SAMPLE_W-1:0] pair_mem [STORE_DEPTH];
  logic signed [SAMPLE_W-1:0] hold_mem [MAX_CHANNELS_DEF];
  int unsigned chan_pos = 0;
  int unsigned col_pos  = 0;
  int unsigned row_pos  = 0;

  // pooled beats still owed by the block, oldest first
  pooled_beat_t window_q[$];

  int unsigned errors    = 0;
  int unsigned beats_in  = 0;
  int unsigned cycle_cnt = 0;
  bit          idle_on   = 1'b1;

  // directed first frame at reset sizes (2x2 pixels, 4 channels), hwc order
  // ch0 all min, ch1 all max, ch2 min/max mixed, ch3 where cascaded halving
  // rounds below the exact quarter sum
  logic signed [SAMPLE_W-1:0] corner_frame [16] = '{
    -8'sd128, 8'sd127, -8'sd128,  8'sd1,
    -8'sd128, 8'sd127,  8'sd127, -8'sd2,
    -8'sd128, 8'sd127,  8'sd127, -8'sd1,
    -8'sd128, 8'sd127, -8'sd128,  8'sd2
  };

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // floor((a+b)/2)
  function automatic logic signed [SAMPLE_W-1:0] halve_sum(
    input logic signed [SAMPLE_W-1:0] a,
    input logic signed [SAMPLE_W-1:0] b
  );
    int sum;
    sum = int'(a) + int'(b);
    return SAMPLE_W'(sum >>> 1);
  endfunction

  // image side after clamping, out-of-range values saturate, zero acts as one
  function automatic int unsigned side_now();
    int unsigned h;
    h = cfg_half;
    if (h < 1) h = 1;
    if (h > MAX_SIDE_DEF / 2) h = MAX_SIDE_DEF / 2;
    return 2 * h;
  endfunction

  function automatic int unsigned chans_now();
    int unsigned g;
    g = cfg_groups;
    if (g < 1) g = 1;
    if (g > MAX_CHANNELS_DEF / 4) g = MAX_CHANNELS_DEF / 4;
    return 4 * g;
  endfunction

  // follow one accepted sample through the window logic
  function automatic void track_sample(input logic signed [SAMPLE_W-1:0] x);
    int unsigned                side;
    int unsigned                chans;
    int unsigned                slot;
    logic signed [SAMPLE_W-1:0] pair;
    pooled_beat_t               beat;
    side  = side_now();
    chans = chans_now();
    slot  = (col_pos >> 1) * chans + chan_pos;
    if ((col_pos & 1) == 0) begin
      // even column: park the sample until its right neighbor shows up
      hold_mem[chan_pos] = x;
    end else begin
      pair = halve_sum(hold_mem[chan_pos], x);
      if ((row_pos & 1) == 0) begin
        // first row of the window: keep the pair average for the next row
        pair_mem[slot] = pair;
      end else begin
        beat.pooled     = halve_sum(pair, pair_mem[slot]);
        beat.frame_last = (row_pos == side - 1) && (col_pos == side - 1) &&
                          (chan_pos == chans - 1);
        window_q.push_back(beat);
      end
    end
    // raster advance; a counter beyond a shrunk limit wraps on its next step
    chan_pos++;
    if (chan_pos >= chans) begin
      chan_pos = 0;
      col_pos++;
      if (col_pos >= side) begin
        col_pos = 0;
        row_pos++;
        if (row_pos >= side) row_pos = 0;
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(input sample_mix_e mix);
    logic signed [SAMPLE_W-1:0] v;
    case (mix)
      MIX_EXTREME: begin
        case ($urandom_range(0, 3))
          0:       v = -8'sd128;
          1:       v = 8'sd127;
          2:       v = -8'sd1;
          default: v = 8'sd0;
        endcase
      end
      MIX_SMALL: v = SAMPLE_W'($urandom_range(0, 7) - 4);
      default:   v = SAMPLE_W'($urandom_range(0, 255));
    endcase
    return v;
  endfunction

  // one sample beat, with an occasional burst of idle cycles ahead of it;
  // valid stays up afterwards so back-to-back beats need no extra step
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] x);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 16);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid  <= 1'b1;
    in_if.sample <= x;
    do @(posedge clk); while (!in_if.ready);
    track_sample(x);
    beats_in++;
  endtask

  task automatic send_samples(input int unsigned count, input sample_mix_e mix);
    repeat (count) send_sample(pick_sample(mix));
  endtask

  // run until the raster is back at the first sample of a frame;
  // from a frame start this is exactly one frame
  task automatic send_frame(input sample_mix_e mix);
    do send_sample(pick_sample(mix));
    while (!(row_pos == 0 && col_pos == 0 && chan_pos == 0));
  endtask

  // stop sending, let every owed beat arrive, then give the pipe time to empty
  task automatic drain();
    in_if.valid <= 1'b0;
    while (window_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // register access
  // ---------------------------------------------------------------------------

  // setup cycle, then access cycles until pready; prdata taken mid-access
  task automatic apb_access(
    input  logic                  wr,
    input  reg_idx_e              idx,
    input  logic [APB_DATA_W-1:0] wdata,
    output logic [APB_DATA_W-1:0] rdata
  );
    logic rdy;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= APB_ADDR_W'(idx) << REG_SEL_BIT;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      rdata = prdata;
      rdy   = pready;
      @(posedge clk);
    end while (!rdy);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_reg(input reg_idx_e idx);
    logic [APB_DATA_W-1:0] rd;
    logic [APB_DATA_W-1:0] want;
    apb_access(1'b0, idx, '0, rd);
    want = (idx == REG_HALF_SIDE) ? APB_DATA_W'(cfg_half) : APB_DATA_W'(cfg_groups);
    if (rd !== want) begin
      errors++;
      $display("%0t: register %s readback: expected %0d, actual %0d",
               $time, idx.name(), want, rd);
    end
  endtask

  // write a register with junk in the unused upper bits, then read it back
  task automatic set_reg(input reg_idx_e idx, input int unsigned value);
    logic [APB_DATA_W-1:0] wd;
    logic [APB_DATA_W-1:0] rd;
    logic [APB_DATA_W-1:0] mask;
    mask = (idx == REG_HALF_SIDE) ? APB_DATA_W'((1 << HALF_SIDE_W) - 1)
                                  : APB_DATA_W'((1 << GROUPS_W) - 1);
    wd = (APB_DATA_W'($urandom()) & ~mask) | (APB_DATA_W'(value) & mask);
    apb_access(1'b1, idx, wd, rd);
    if (idx == REG_HALF_SIDE) cfg_half = wd[HALF_SIDE_W-1:0];
    else cfg_groups = wd[GROUPS_W-1:0];
    check_reg(idx);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // registers come up at 1/1, first frame with extreme and rounding corners
  task automatic test_reset_values();
    check_reg(REG_HALF_SIDE);
    check_reg(REG_CHANNEL_GROUPS);
    foreach (corner_frame[i]) send_sample(corner_frame[i]);
  endtask

  // zero in either register behaves as one
  task automatic test_zero_registers();
    drain();
    set_reg(REG_HALF_SIDE, 0);
    set_reg(REG_CHANNEL_GROUPS, 0);
    send_frame(MIX_UNIFORM);
  endtask

  // widest pixel, then a group count beyond the limit that must saturate
  task automatic test_channel_limit();
    drain();
    set_reg(REG_HALF_SIDE, 1);
    set_reg(REG_CHANNEL_GROUPS, MAX_CHANNELS_DEF / 4);
    send_frame(MIX_UNIFORM);
    drain();
    set_reg(REG_CHANNEL_GROUPS, (1 << GROUPS_W) - 1);
    send_frame(MIX_EXTREME);
  endtask

  // shrink the side in the middle of an odd row: the window in flight closes
  // under the new size and the frame ends early.
  // a full frame at the larger size runs first so every store entry read is written
  task automatic test_mid_frame_resize();
    drain();
    set_reg(REG_CHANNEL_GROUPS, 1);
    set_reg(REG_HALF_SIDE, 3);
    send_frame(MIX_UNIFORM);
    send_samples((3 * side_now() + 2) * chans_now(), MIX_UNIFORM);
    drain();
    set_reg(REG_HALF_SIDE, 2);
    send_frame(MIX_UNIFORM);
    send_frame(MIX_SMALL);
  endtask

  // many small frames with random sizes, content and idling
  task automatic test_random_frames();
    int unsigned target;
    target = beats_in + RANDOM_BEATS;
    while (beats_in < target) begin
      drain();
      idle_on = ($urandom_range(0, 3) != 0);
      // sizes mostly 1..3, now and then zero or one step larger
      set_reg(REG_HALF_SIDE, $urandom_range(0, 9) == 0 ? $urandom_range(0, 4)
                                                      : $urandom_range(1, 3));
      set_reg(REG_CHANNEL_GROUPS, $urandom_range(0, 9) == 0 ? $urandom_range(0, 4)
                                                           : $urandom_range(1, 3));
      repeat ($urandom_range(1, 2)) send_frame(sample_mix_e'($urandom_range(0, 2)));
    end
  endtask

  // first row of the largest side, then a side value beyond the limit that
  // clamps to the same size for the second row; a small side then wraps the
  // raster back to a frame start. the last part runs with no idling on either side
  task automatic test_side_limit();
    drain();
    idle_on = 1'b1;
    set_reg(REG_CHANNEL_GROUPS, 1);
    set_reg(REG_HALF_SIDE, MAX_SIDE_DEF / 2);
    send_samples(side_now() * chans_now(), MIX_UNIFORM);
    drain();
    idle_on = 1'b0;
    set_reg(REG_HALF_SIDE, (1 << HALF_SIDE_W) - 1);
    send_samples(side_now() * chans_now(), MIX_UNIFORM);
    drain();
    set_reg(REG_HALF_SIDE, 1);
    send_frame(MIX_UNIFORM);
    send_frame(MIX_EXTREME);
  endtask

  // ---------------------------------------------------------------------------
  // sink side: ready held low in random bursts while idling is on
  // ---------------------------------------------------------------------------
  initial begin : sink_stall
    int unsigned hold;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 16);
        out_if.ready <= 1'b0;
        repeat (hold - 1) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result checking: every output beat against the oldest owed beat
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : pooled_check
    pooled_beat_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (window_q.size() == 0) begin
        errors++;
        $display("%0t: pooled beat with nothing owed: expected none, actual %0d last %0b",
                 $time, out_if.pooled, out_if.frame_last);
      end else begin
        want = window_q.pop_front();
        if (out_if.pooled !== want.pooled) begin
          errors++;
          $display("%0t: pooled mismatch: expected %0d, actual %0d",
                   $time, want.pooled, out_if.pooled);
        end
        if (out_if.frame_last !== want.frame_last) begin
          errors++;
          $display("%0t: frame_last mismatch: expected %0b, actual %0b",
                   $time, want.frame_last, out_if.frame_last);
        end
      end
    end
  end

  // hang guard
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    // every block input known from time zero while reset is held
    rst_n        <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.sample <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_zero_registers();
    test_channel_limit();
    test_mid_frame_resize();
    test_random_frames();
    test_side_limit();

    // wait for every owed beat and the settle time after it for stray output
    drain();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
